### rtl/scrolling_text_console_macros.svh
`ifndef SCROLLING_TEXT_CONSOLE_MACROS_SVH
`define SCROLLING_TEXT_CONSOLE_MACROS_SVH

// Check a condition at every edge outside reset
`define STC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the cycle after its cause
`define STC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/stc_pkg.sv
`timescale 1ns / 1ps

package stc_pkg;

    localparam int SCREEN_LINES_DEF   = 25;
    localparam int SCREEN_COLUMNS_DEF = 80;
    localparam int CELL_W             = 16;

    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_SPACE   = 8'd32;
    localparam logic [7:0] ATTR_RESET   = 8'd7;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_code;
        logic [4:0] display_row;
        logic [6:0] display_column;
    } cmd_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
    } rsp_t;

endpackage

### rtl/stc_if.sv
`timescale 1ns / 1ps

interface stc_cmd_if;
    logic          valid;
    logic          ready;
    stc_pkg::cmd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface stc_rsp_if;
    logic          valid;
    logic          ready;
    stc_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/stc_ram.sv
`timescale 1ns / 1ps

module stc_ram #(
    parameter int WIDTH = stc_pkg::CELL_W,
    parameter int DEPTH = stc_pkg::SCREEN_LINES_DEF * stc_pkg::SCREEN_COLUMNS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/scrolling_text_console.sv
`timescale 1ns / 1ps
// Scrolling text console over a ring of SCREEN_LINES lines by SCREEN_COLUMNS cells.
// cmd: one transaction per command (put character, read display cell, clear screen);
// a transaction is taken when valid and ready are high at a clock edge.
// rsp: one transaction per command, with the read cell (zero for other modes) and
// the cursor line and column after the command.
// cfg_we/cfg_wdata: write the attribute byte stored beside every written character.
// Steps from command to result, set by the sequencer over the cell RAM:
//   put: write the cell; read: address, then capture the cell; unused mode: no step;
//   newline or wrap: pad, then blank the new line;
//   clear: every cell blanked, one cell written a cycle.
// One command is in progress at a time; ready rises again once its result is staged.
// After reset all SCREEN_LINES*SCREEN_COLUMNS cells (2000 by default) are zeroed
// before the first command is taken; configuration writes are taken throughout.
// When the receiver stalls, the result is held in the output register; the next
// command is still taken and its result waits until the register frees.
`include "scrolling_text_console_macros.svh"

module scrolling_text_console #(
    parameter int SCREEN_LINES   = stc_pkg::SCREEN_LINES_DEF,
    parameter int SCREEN_COLUMNS = stc_pkg::SCREEN_COLUMNS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    stc_cmd_if.sink    cmd,
    stc_rsp_if.source  rsp,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    localparam int DEPTH = SCREEN_LINES * SCREEN_COLUMNS;
    localparam int LW    = $clog2(SCREEN_LINES);
    localparam int CW    = $clog2(SCREEN_COLUMNS);
    localparam int CPW   = $clog2(SCREEN_COLUMNS + 1);
    localparam int AW    = $clog2(DEPTH);

    localparam logic [AW-1:0]  COLS_A    = AW'(SCREEN_COLUMNS);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [LW-1:0]  LAST_LINE = LW'(SCREEN_LINES - 1);
    localparam logic [LW:0]    LINES_X   = (LW + 1)'(SCREEN_LINES);
    localparam logic [CPW-1:0] COLS_P    = CPW'(SCREEN_COLUMNS);
    localparam logic [CPW-1:0] LAST_COL  = CPW'(SCREEN_COLUMNS - 1);

    localparam logic [3:0] ST_INIT     = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_NL_PAD   = 4'd2;
    localparam logic [3:0] ST_NL_BLANK = 4'd3;
    localparam logic [3:0] ST_PUT      = 4'd4;
    localparam logic [3:0] ST_CLEAR    = 4'd5;
    localparam logic [3:0] ST_RD_ADDR  = 4'd6;
    localparam logic [3:0] ST_RD_DATA  = 4'd7;
    localparam logic [3:0] ST_FINISH   = 4'd8;

    logic [3:0]     state_reg, state_next;
    logic [LW-1:0]  line_ptr_reg, line_ptr_next;
    logic [CPW-1:0] col_ptr_reg, col_ptr_next;
    logic [AW-1:0]  sweep_reg, sweep_next;
    logic [7:0]     attr_reg, attr_next;
    logic           pend_reg, pend_next;
    logic           out_valid_reg, out_valid_next;

    logic [7:0]     char_reg, char_next;
    logic [LW-1:0]  rd_row_reg, rd_row_next;
    logic [CW-1:0]  rd_col_reg, rd_col_next;
    logic           rd_ok_reg, rd_ok_next;
    logic [7:0]     res_char_reg, res_char_next;
    logic [7:0]     res_attr_reg, res_attr_next;
    stc_pkg::rsp_t  out_reg, out_next;

    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [stc_pkg::CELL_W-1:0] mem_wdata;
    logic                      mem_re;
    logic [AW-1:0]             mem_raddr;
    logic [stc_pkg::CELL_W-1:0] mem_rdata;

    logic [AW-1:0] cursor_addr;
    logic [LW:0]   rd_sum;
    logic [LW-1:0] rd_line;
    logic          sweep_last;
    logic [stc_pkg::CELL_W-1:0] space_cell;

    stc_ram #(
        .WIDTH (stc_pkg::CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cursor_addr = AW'(line_ptr_reg) * COLS_A + AW'(col_ptr_reg);
    assign rd_sum      = {1'b0, line_ptr_reg} + {1'b0, rd_row_reg} + (LW + 1)'(1);
    assign rd_line     = (rd_sum >= LINES_X) ? LW'(rd_sum - LINES_X) : LW'(rd_sum);
    assign mem_raddr   = AW'(rd_line) * COLS_A + AW'(rd_col_reg);
    assign sweep_last  = (sweep_reg == LAST_ADDR);
    assign space_cell  = {attr_reg, stc_pkg::CODE_SPACE};

    assign cmd.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        line_ptr_next  = line_ptr_reg;
        col_ptr_next   = col_ptr_reg;
        sweep_next     = sweep_reg;
        attr_next      = cfg_we ? cfg_wdata : attr_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        rd_row_next    = rd_row_reg;
        rd_col_next    = rd_col_reg;
        rd_ok_next     = rd_ok_reg;
        res_char_next  = res_char_reg;
        res_attr_next  = res_attr_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = cursor_addr;
        mem_wdata      = space_cell;
        mem_re         = 1'b0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = '0;
                if (sweep_last)
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    res_char_next = '0;
                    res_attr_next = '0;
                    char_next     = cmd.payload.char_code;
                    rd_row_next   = LW'(cmd.payload.display_row);
                    rd_col_next   = CW'(cmd.payload.display_column);
                    rd_ok_next    = (32'(cmd.payload.display_row) < 32'(SCREEN_LINES))
                                 && (32'(cmd.payload.display_column) < 32'(SCREEN_COLUMNS));
                    unique case (cmd.payload.mode)
                        stc_pkg::MODE_PUT:
                        begin
                            if (cmd.payload.char_code == stc_pkg::CODE_NEWLINE)
                            begin
                                pend_next  = 1'b0;
                                state_next = ST_NL_PAD;
                            end
                            else if (col_ptr_reg == COLS_P)
                            begin
                                pend_next  = 1'b1;
                                state_next = ST_NL_PAD;
                            end
                            else
                            begin
                                state_next = ST_PUT;
                            end
                        end
                        stc_pkg::MODE_READ:
                        begin
                            state_next = ST_RD_ADDR;
                        end
                        stc_pkg::MODE_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_NL_PAD:
            begin
                if (col_ptr_reg < COLS_P)
                begin
                    mem_we       = 1'b1;
                    col_ptr_next = col_ptr_reg + CPW'(1);
                end
                else
                begin
                    col_ptr_next  = '0;
                    line_ptr_next = (line_ptr_reg == LAST_LINE) ? '0
                                                                : line_ptr_reg + LW'(1);
                    state_next    = ST_NL_BLANK;
                end
            end
            ST_NL_BLANK:
            begin
                mem_we = 1'b1;
                if (col_ptr_reg == LAST_COL)
                begin
                    col_ptr_next = '0;
                    state_next   = pend_reg ? ST_PUT : ST_FINISH;
                end
                else
                begin
                    col_ptr_next = col_ptr_reg + CPW'(1);
                end
            end
            ST_PUT:
            begin
                mem_we       = 1'b1;
                mem_wdata    = {attr_reg, char_reg};
                col_ptr_next = col_ptr_reg + CPW'(1);
                state_next   = ST_FINISH;
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                if (sweep_last)
                begin
                    sweep_next    = '0;
                    line_ptr_next = '0;
                    col_ptr_next  = '0;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            ST_RD_ADDR:
            begin
                mem_re     = rd_ok_reg;
                state_next = rd_ok_reg ? ST_RD_DATA : ST_FINISH;
            end
            ST_RD_DATA:
            begin
                res_char_next = mem_rdata[7:0];
                res_attr_next = mem_rdata[15:8];
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next      = 1'b1;
                    out_next.cell_char  = res_char_reg;
                    out_next.cell_attr  = res_attr_reg;
                    out_next.cursor_row = 5'(line_ptr_reg);
                    out_next.cursor_col = 7'(col_ptr_reg);
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            line_ptr_reg  <= '0;
            col_ptr_reg   <= '0;
            sweep_reg     <= '0;
            attr_reg      <= stc_pkg::ATTR_RESET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            line_ptr_reg  <= line_ptr_next;
            col_ptr_reg   <= col_ptr_next;
            sweep_reg     <= sweep_next;
            attr_reg      <= attr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        rd_row_reg   <= rd_row_next;
        rd_col_reg   <= rd_col_next;
        rd_ok_reg    <= rd_ok_next;
        res_char_reg <= res_char_next;
        res_attr_reg <= res_attr_next;
        out_reg      <= out_next;
    end

    `STC_ASSERT_ALWAYS(a_col_bound, clk, rst_n, col_ptr_reg <= COLS_P,
        "cursor column beyond line end")
    `STC_ASSERT_ALWAYS(a_line_bound, clk, rst_n, line_ptr_reg <= LAST_LINE,
        "cursor line outside ring")
    `STC_ASSERT_ALWAYS(a_waddr_bound, clk, rst_n, !mem_we || (32'(mem_waddr) < 32'(DEPTH)),
        "cell write outside screen")
    `STC_ASSERT_NEXT(a_clear_home, clk, rst_n, (state_reg == ST_CLEAR) && sweep_last,
        (line_ptr_reg == '0) && (col_ptr_reg == '0), "cursor not homed after clear")

endmodule

### dv/tb_scrolling_text_console.sv
`timescale 1ns / 1ps

module tb_scrolling_text_console;

    localparam int LINES           = stc_pkg::SCREEN_LINES_DEF;
    localparam int COLUMNS         = stc_pkg::SCREEN_COLUMNS_DEF;
    localparam int IDLE_LIMIT      = 20000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 2 * COLUMNS + 8;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    stc_cmd_if cmd_ch ();
    stc_rsp_if rsp_ch ();

    scrolling_text_console DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    stc_pkg::cmd_t pending_commands[$];
    stc_pkg::rsp_t expected_results[$];

    logic [15:0] cell_store [LINES * COLUMNS];
    int          cursor_line;
    int          cursor_column;
    logic [7:0]  attr_shadow;

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_armed;
    bit  hold_done;
    int  hold_left;
    bit  cmd_taken;
    bit  rsp_taken;
    int  quiet_cycles;
    int  failures;

    always #6 clk = ~clk;

    function automatic void blank_cells(int line, int from);
        for (int c = from; c < COLUMNS; c++)
            cell_store[line * COLUMNS + c] = {attr_shadow, stc_pkg::CODE_SPACE};
    endfunction

    function automatic void advance_line();
        blank_cells(cursor_line, cursor_column);
        cursor_column = 0;
        cursor_line   = (cursor_line + 1) % LINES;
        blank_cells(cursor_line, 0);
    endfunction

    function automatic stc_pkg::rsp_t console_step(stc_pkg::cmd_t c);
        stc_pkg::rsp_t r;
        int            ln;
        r = '0;
        case (c.mode)
            stc_pkg::MODE_PUT:
            begin
                if (c.char_code == stc_pkg::CODE_NEWLINE)
                    advance_line();
                else
                begin
                    if (cursor_column >= COLUMNS)
                        advance_line();
                    cell_store[cursor_line * COLUMNS + cursor_column] =
                        {attr_shadow, c.char_code};
                    cursor_column++;
                end
            end
            stc_pkg::MODE_READ:
            begin
                if (c.display_row < LINES && c.display_column < COLUMNS)
                begin
                    ln = (cursor_line + 1 + int'(c.display_row)) % LINES;
                    {r.cell_attr, r.cell_char} = cell_store[ln * COLUMNS + c.display_column];
                end
            end
            stc_pkg::MODE_CLEAR:
            begin
                for (int l = 0; l < LINES; l++)
                    blank_cells(l, 0);
                cursor_line   = 0;
                cursor_column = 0;
            end
            default:
            begin
            end
        endcase
        r.cursor_row = cursor_line[4:0];
        r.cursor_col = cursor_column[6:0];
        return r;
    endfunction

    function automatic stc_pkg::cmd_t make_cmd(logic [1:0] m, logic [7:0] ch,
                                               logic [4:0] row, logic [6:0] col);
        stc_pkg::cmd_t c;
        c.mode           = m;
        c.char_code      = ch;
        c.display_row    = row;
        c.display_column = col;
        return c;
    endfunction

    function automatic logic [7:0] random_glyph();
        logic [7:0] g;
        if ($urandom_range(9) < 8)
            return 8'($urandom_range(126, 32));
        do
            g = 8'($urandom_range(255));
        while (g == stc_pkg::CODE_NEWLINE);
        return g;
    endfunction

    task automatic queue_put(logic [7:0] ch);
        pending_commands.push_back(make_cmd(stc_pkg::MODE_PUT, ch, 5'($urandom_range(31)),
                                            7'($urandom_range(127))));
    endtask

    task automatic queue_read(int row, int col);
        pending_commands.push_back(make_cmd(stc_pkg::MODE_READ, 8'($urandom_range(255)),
                                            5'(row), 7'(col)));
    endtask

    task automatic queue_random_read();
        int row;
        int col;
        row = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(LINES - 1);
        col = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(COLUMNS - 1);
        queue_read(row, col);
    endtask

    task automatic build_traffic(int total);
        int kind;
        int len;
        int sel;
        while (pending_commands.size() < total)
        begin
            kind = $urandom_range(99);
            if (kind < 45)
            begin
                sel = $urandom_range(9);
                len = (sel < 5) ? $urandom_range(20, 1) :
                      (sel < 8) ? $urandom_range(100, 60) : COLUMNS;
                for (int i = 0; i < len; i++)
                begin
                    queue_put(random_glyph());
                    if ($urandom_range(9) == 0)
                        queue_random_read();
                end
                if ($urandom_range(1))
                    queue_put(stc_pkg::CODE_NEWLINE);
            end
            else if (kind < 75)
            begin
                len = $urandom_range(6, 1);
                for (int i = 0; i < len; i++)
                    queue_random_read();
            end
            else if (kind < 85)
            begin
                len = $urandom_range(3, 1);
                for (int i = 0; i < len; i++)
                    queue_put(stc_pkg::CODE_NEWLINE);
            end
            else if (kind < 90)
                pending_commands.push_back(make_cmd(MODE_UNUSED, 8'($urandom_range(255)),
                                                    5'($urandom_range(31)),
                                                    7'($urandom_range(127))));
            else if (kind < 94)
                pending_commands.push_back(make_cmd(stc_pkg::MODE_CLEAR,
                                                    8'($urandom_range(255)),
                                                    5'($urandom_range(31)),
                                                    7'($urandom_range(127))));
            else
                pending_commands.push_back(make_cmd(2'($urandom_range(3)),
                                                    8'($urandom_range(255)),
                                                    5'($urandom_range(31)),
                                                    7'($urandom_range(127))));
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_commands.size() != 0 || cmd_ch.valid || expected_results.size() != 0);
    endtask

    task automatic write_attribute(logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        attr_shadow = value;
    endtask

    // command driver
    always @(negedge clk)
    begin
        if (!cmd_ch.valid || cmd_taken)
        begin
            if (pending_commands.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cmd_ch.payload <= pending_commands.pop_front();
                cmd_ch.valid   <= 1'b1;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_armed && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        stc_pkg::rsp_t got;
        stc_pkg::rsp_t want;
        if (rst_n)
        begin
            cmd_taken = cmd_ch.valid && cmd_ch.ready;
            rsp_taken = rsp_ch.valid && rsp_ch.ready;
            if (rsp_taken)
            begin
                got = rsp_ch.payload;
                if (expected_results.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result transaction: ",
                                 "char %0d attr %0d row %0d col %0d",
                                 got.cell_char, got.cell_attr, got.cursor_row,
                                 got.cursor_col);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr ||
                        got.cursor_row !== want.cursor_row ||
                        got.cursor_col !== want.cursor_col)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("mismatch: expected char %0d attr %0d row %0d col %0d,",
                                     want.cell_char, want.cell_attr, want.cursor_row,
                                     want.cursor_col,
                                     " got char %0d attr %0d row %0d col %0d",
                                     got.cell_char, got.cell_attr,
                                     got.cursor_row, got.cursor_col);
                    end
                end
            end
            if (cmd_taken)
                expected_results.push_back(console_step(cmd_ch.payload));
            if (cmd_taken || rsp_taken)
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= IDLE_LIMIT)
                begin
                    $display("scrolling_text_console regression: fail");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        send_idle_pct  = 22;
        recv_idle_pct  = 49;
        hold_armed     = 1'b0;
        hold_done      = 1'b0;
        hold_left      = 0;
        cmd_taken      = 1'b0;
        rsp_taken      = 1'b0;
        quiet_cycles   = 0;
        failures       = 0;
        cursor_line    = 0;
        cursor_column  = 0;
        attr_shadow    = stc_pkg::ATTR_RESET;
        foreach (cell_store[i])
            cell_store[i] = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_read(0, 0);
        queue_read(LINES - 1, COLUMNS - 1);
        pending_commands.push_back(make_cmd(MODE_UNUSED, 8'hFF, 5'h1F, 7'h7F));
        queue_put(8'd65);
        queue_put(8'd0);
        queue_put(8'd255);
        queue_put(stc_pkg::CODE_NEWLINE);
        queue_put(stc_pkg::CODE_NEWLINE);
        for (int c = 0; c < 4; c++)
            queue_read(LINES - 3, c);
        queue_read(LINES, 0);
        queue_read(31, 127);
        queue_read(0, COLUMNS);
        queue_read(LINES - 1, 127);
        pending_commands.push_back(make_cmd(stc_pkg::MODE_CLEAR, 8'h00, 5'h00, 7'h00));
        queue_read(LINES - 1, 0);
        queue_put(8'd122);
        queue_read(LINES - 1, 0);
        pending_commands.push_back(make_cmd(MODE_UNUSED, 8'h00, 5'h00, 7'h00));
        queue_read(0, COLUMNS - 1);
        wait_idle();

        write_attribute(8'h00);
        for (int i = 0; i < COLUMNS; i++)
            queue_put(random_glyph());
        queue_put(stc_pkg::CODE_NEWLINE);
        for (int i = 0; i < COLUMNS + 5; i++)
            queue_put(random_glyph());
        build_traffic(340);
        wait_idle();

        send_idle_pct = 49;
        recv_idle_pct = 22;
        write_attribute(8'hFF);
        build_traffic(340);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_attribute(8'($urandom_range(254, 1)));
        build_traffic(350);
        hold_armed = 1'b1;
        wait_idle();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (failures == 0 && expected_results.size() == 0)
            $display("scrolling_text_console regression: pass");
        else
            $display("scrolling_text_console regression: fail");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/stc_pkg.sv
rtl/stc_if.sv
rtl/stc_ram.sv
rtl/scrolling_text_console.sv
dv/tb_scrolling_text_console.sv
